>>> rtl/qtm_pkg.sv
// Shared types and constants for the quaternion TRS matrix builder.
`timescale 1ns / 1ps
`default_nettype none
package qtm_pkg;

  // Default field widths.
  localparam int QuatWidthDef  = 16;
  localparam int CoordWidthDef = 32;

  // Normalized quaternion components are signed Q1.14 held in 16 bits.
  localparam int QOW = 16;
  localparam int QFRAC = 14;
  // Shifted component magnitudes never exceed 32768.
  localparam int AW = 16;
  localparam int AMAX = 32768;
  // Square of a shifted magnitude, and the sum of four of them.
  localparam int SQW = 32;
  localparam int LW = 34;
  // Root search accumulators; the largest candidate stays below 2^65.
  localparam int FW = 68;
  localparam int NSTEP = QFRAC + 1;
  // Rotation entries are signed Q2.28 with magnitude at most 2^28.
  localparam int RW = 31;
  localparam int MRW = 29;
  localparam int RFRAC = 28;
  // Scale magnitudes are widened to the largest supported coordinate width.
  localparam int MSW = 48;
  localparam int SPLIT = 24;
  localparam int PW = MRW + SPLIT;
  localparam int MAGW = 54;

  // Row numbers of one item.
  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_LAST  = 2'd2;

  typedef struct packed {
    logic valid;
    logic degen;
  } ctl_t;

endpackage
`default_nettype wire

>>> rtl/qtm_norm.sv
// Quaternion normalization pipeline: pre-shift, squares, bitwise root search.
`timescale 1ns / 1ps
`default_nettype none
module qtm_norm import qtm_pkg::*; #(
  parameter int QW = QuatWidthDef,
  parameter int SW = 6 * CoordWidthDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  input  wire logic [3:0][QW-1:0]      quat_i,
  input  wire logic [SW-1:0]           side_i,
  output logic      [3:0][QOW-1:0]     q_o,
  output ctl_t                         ctl_o,
  output logic      [SW-1:0]           side_o
);

  localparam int EW = AW + QW;
  localparam int SHW = $clog2(QW);

  // Stage 1: magnitudes and signs.
  logic                 vld1_q;
  logic [3:0][QW-1:0]   mag1_d, mag1_q;
  logic [3:0]           neg1_q;
  logic                 degen1_q;
  logic [SW-1:0]        side1_q;

  // Stage 2: pre-shift amount.
  logic                 vld2_q;
  logic [3:0][QW-1:0]   mag2_q;
  logic [SHW-1:0]       sh2_d, sh2_q;
  logic [3:0]           neg2_q;
  logic                 degen2_q;
  logic [SW-1:0]        side2_q;

  // Stage 3: shifted magnitudes.
  logic                 vld3_q;
  logic [3:0][AW-1:0]   a3_d, a3_q;
  logic [3:0]           neg3_q;
  logic                 degen3_q;
  logic [SW-1:0]        side3_q;

  // Stage 4: squares.
  logic                 vld4_q;
  logic [3:0][SQW-1:0]  sq4_q;
  logic [3:0]           neg4_q;
  logic                 degen4_q;
  logic [SW-1:0]        side4_q;

  // Root search stages; entry 0 is the starting point.
  logic                 vld_q   [NSTEP+1];
  logic                 degen_q [NSTEP+1];
  logic [3:0]           neg_q   [NSTEP+1];
  logic [SW-1:0]        side_q  [NSTEP+1];
  logic [LW-1:0]        len_q   [NSTEP+1];
  logic signed [FW-1:0] nn_q    [NSTEP+1][4];
  logic signed [FW-1:0] f_q     [NSTEP+1][4];
  logic signed [FW-1:0] g_q     [NSTEP+1][4];
  logic [QFRAC:0]       n_q     [NSTEP+1][4];

  logic                 vldo_q;
  logic                 degeno_q;
  logic [3:0][QOW-1:0]  q_d;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      mag1_d[l] = quat_i[l][QW-1] ? (~quat_i[l] + QW'(1)) : quat_i[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      vld1_q <= in_valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  // Smallest shift that brings the largest magnitude to 32768 or less.
  always_comb begin
    logic [QW-1:0] mx;
    mx = '0;
    for (int l = 0; l < 4; l++) begin
      if (mag1_q[l] > mx) mx = mag1_q[l];
    end
    sh2_d = '0;
    for (int s = QW - 1; s >= 0; s--) begin
      if ((EW'(mx) >> s) <= EW'(AMAX)) sh2_d = SHW'(s);
    end
  end

  always_comb begin
    logic [EW-1:0] sv;
    for (int l = 0; l < 4; l++) begin
      sv = EW'(mag2_q[l]) >> sh2_q;
      a3_d[l] = sv[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    mag1_q   <= mag1_d;
    for (int l = 0; l < 4; l++) neg1_q[l] <= quat_i[l][QW-1];
    degen1_q <= (quat_i == '0);
    side1_q  <= side_i;

    mag2_q   <= mag1_q;
    sh2_q    <= sh2_d;
    neg2_q   <= neg1_q;
    degen2_q <= degen1_q;
    side2_q  <= side1_q;

    a3_q     <= a3_d;
    neg3_q   <= neg2_q;
    degen3_q <= degen2_q;
    side3_q  <= side2_q;

    for (int l = 0; l < 4; l++) sq4_q[l] <= SQW'(a3_q[l]) * SQW'(a3_q[l]);
    neg4_q   <= neg3_q;
    degen4_q <= degen3_q;
    side4_q  <= side3_q;
  end

  // Starting point of the search: n = 0, f = (2n-1)^2 * L, g = (2n-1) * L.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= vld4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [LW-1:0] len;
    len = LW'(sq4_q[0]) + LW'(sq4_q[1]) + LW'(sq4_q[2]) + LW'(sq4_q[3]);
    len_q[0]   <= len;
    degen_q[0] <= degen4_q;
    neg_q[0]   <= neg4_q;
    side_q[0]  <= side4_q;
    for (int l = 0; l < 4; l++) begin
      nn_q[0][l] <= FW'(sq4_q[l]) << 30;
      f_q[0][l]  <= FW'(len);
      g_q[0][l]  <= -$signed(FW'(len));
      n_q[0][l]  <= '0;
    end
  end

  // One result bit per stage, most significant first. Adding bit b to n moves
  // (2n-1)^2 * L by g * 2^(b+2) + L * 2^(2b+2), so no multiplier is needed.
  for (genvar k = 1; k <= NSTEP; k++) begin : g_step
    localparam int B = NSTEP - k;
    logic signed [FW-1:0] f_d [4];
    logic signed [FW-1:0] g_d [4];
    logic [QFRAC:0]       n_d [4];

    always_comb begin
      logic signed [FW-1:0] ft;
      logic signed [FW-1:0] lw;
      lw = $signed(FW'(len_q[k-1]));
      for (int l = 0; l < 4; l++) begin
        ft = f_q[k-1][l] + (g_q[k-1][l] <<< (B + 2)) + (lw <<< (2 * B + 2));
        if (!n_q[k-1][l][QFRAC] && (ft <= nn_q[k-1][l])) begin
          f_d[l] = ft;
          g_d[l] = g_q[k-1][l] + (lw <<< (B + 1));
          n_d[l] = n_q[k-1][l] | (QFRAC + 1)'(1 << B);
        end else begin
          f_d[l] = f_q[k-1][l];
          g_d[l] = g_q[k-1][l];
          n_d[l] = n_q[k-1][l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      len_q[k]   <= len_q[k-1];
      degen_q[k] <= degen_q[k-1];
      neg_q[k]   <= neg_q[k-1];
      side_q[k]  <= side_q[k-1];
      for (int l = 0; l < 4; l++) begin
        nn_q[k][l] <= nn_q[k-1][l];
        f_q[k][l]  <= f_d[l];
        g_q[k][l]  <= g_d[l];
        n_q[k][l]  <= n_d[l];
      end
    end
  end

  // Signs go back on; the zero quaternion becomes the identity.
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (degen_q[NSTEP]) begin
        q_d[l] = (l == 3) ? QOW'(1 << QFRAC) : '0;
      end else if (neg_q[NSTEP][l]) begin
        q_d[l] = -QOW'(n_q[NSTEP][l]);
      end else begin
        q_d[l] = QOW'(n_q[NSTEP][l]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldo_q <= 1'b0;
    end else begin
      vldo_q <= vld_q[NSTEP];
    end
  end

  always_ff @(posedge clk_i) begin
    q_o      <= q_d;
    degeno_q <= degen_q[NSTEP];
    side_o   <= side_q[NSTEP];
  end

  assign ctl_o = '{valid: vldo_q, degen: degeno_q};

endmodule
`default_nettype wire

>>> rtl/qtm_rot.sv
// Rotation matrix entries in Q2.28 from a unit quaternion, two stages.
`timescale 1ns / 1ps
`default_nettype none
module qtm_rot import qtm_pkg::*; #(
  parameter int SW = 6 * CoordWidthDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [3:0][QOW-1:0]   q_i,
  input  wire ctl_t                  ctl_i,
  input  wire logic [SW-1:0]         side_i,
  output logic      [8:0][RW-1:0]    rot_o,
  output ctl_t                       ctl_o,
  output logic      [SW-1:0]         side_o
);

  localparam int PRW = 2 * QOW;
  localparam int EXW = PRW + 2;

  logic signed [PRW-1:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic                  vlda_q, vldb_q;
  logic                  degena_q, degenb_q;
  logic [SW-1:0]         sidea_q;
  logic [8:0][RW-1:0]    rot_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlda_q <= 1'b0;
      vldb_q <= 1'b0;
    end else begin
      vlda_q <= ctl_i.valid;
      vldb_q <= vlda_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [QOW-1:0] x, y, z, w;
    x = $signed(q_i[0]);
    y = $signed(q_i[1]);
    z = $signed(q_i[2]);
    w = $signed(q_i[3]);
    xx_q <= x * x;
    yy_q <= y * y;
    zz_q <= z * z;
    xy_q <= x * y;
    xz_q <= x * z;
    yz_q <= y * z;
    wx_q <= w * x;
    wy_q <= w * y;
    wz_q <= w * z;
    degena_q <= ctl_i.degen;
    sidea_q  <= side_i;
  end

  always_comb begin
    logic signed [EXW-1:0] one;
    logic signed [EXW-1:0] e [9];
    one  = EXW'(1) <<< RFRAC;
    e[0] = one - ((EXW'(yy_q) + EXW'(zz_q)) <<< 1);
    e[1] = (EXW'(xy_q) - EXW'(wz_q)) <<< 1;
    e[2] = (EXW'(xz_q) + EXW'(wy_q)) <<< 1;
    e[3] = (EXW'(xy_q) + EXW'(wz_q)) <<< 1;
    e[4] = one - ((EXW'(xx_q) + EXW'(zz_q)) <<< 1);
    e[5] = (EXW'(yz_q) - EXW'(wx_q)) <<< 1;
    e[6] = (EXW'(xz_q) - EXW'(wy_q)) <<< 1;
    e[7] = (EXW'(yz_q) + EXW'(wx_q)) <<< 1;
    e[8] = one - ((EXW'(xx_q) + EXW'(yy_q)) <<< 1);
    for (int k = 0; k < 9; k++) rot_d[k] = e[k][RW-1:0];
  end

  always_ff @(posedge clk_i) begin
    rot_o    <= rot_d;
    degenb_q <= degena_q;
    side_o   <= sidea_q;
  end

  assign ctl_o = '{valid: vldb_q, degen: degenb_q};

endmodule
`default_nettype wire

>>> rtl/qtm_row.sv
// Row sequencer and scaling pipeline: one matrix row per cycle, three per item.
`timescale 1ns / 1ps
`default_nettype none
module qtm_row import qtm_pkg::*; #(
  parameter int CW = CoordWidthDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [8:0][RW-1:0]   rot_i,
  input  wire ctl_t                 ctl_i,
  input  wire logic [6*CW-1:0]      side_i,
  output logic                      result_valid_o,
  output logic      [1:0]           row_index_o,
  output logic      [CW-1:0]        col0_o,
  output logic      [CW-1:0]        col1_o,
  output logic      [CW-1:0]        col2_o,
  output logic      [CW-1:0]        col3_o,
  output logic                      last_row_o,
  output logic                      degenerate_o
);

  // Item buffer, held while its three rows go out.
  logic                active_q;
  logic [1:0]          row_q;
  logic [8:0][RW-1:0]  rot_q;
  logic [6*CW-1:0]     side_q;
  logic                degen_q;

  // Prepare stage.
  logic                vldp_q;
  logic [2:0][MRW-1:0] mr_q;
  logic [2:0][MSW-1:0] ms_q;
  logic [2:0]          negp_q;
  logic [CW-1:0]       posp_q;
  logic [1:0]          rowp_q;
  logic                degenp_q;

  // Multiply stage.
  logic                vldm_q;
  logic [2:0][PW-1:0]  phi_q, plo_q;
  logic [2:0]          negm_q;
  logic [CW-1:0]       posm_q;
  logic [1:0]          rowm_q;
  logic                degenm_q;

  logic                vldo_q;
  logic [2:0][CW-1:0]  col_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      row_q    <= ROW_FIRST;
      vldp_q   <= 1'b0;
      vldm_q   <= 1'b0;
      vldo_q   <= 1'b0;
    end else begin
      // Items arrive spaced by the busy_o gap at the top, so a new one lands no
      // earlier than when the last row of the previous one has been taken.
      if (ctl_i.valid) begin
        active_q <= 1'b1;
        row_q    <= ROW_FIRST;
      end else if (active_q) begin
        if (row_q == ROW_LAST) active_q <= 1'b0;
        row_q <= row_q + 2'd1;
      end
      vldp_q <= active_q;
      vldm_q <= vldp_q;
      vldo_q <= vldm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      rot_q   <= rot_i;
      side_q  <= side_i;
      degen_q <= ctl_i.degen;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [RW-1:0] e;
    logic signed [CW-1:0] s;
    logic [RW-1:0]        em;
    logic [CW-1:0]        sm;
    for (int c = 0; c < 3; c++) begin
      case (row_q)
        2'd0:    e = $signed(rot_q[c]);
        2'd1:    e = $signed(rot_q[3 + c]);
        default: e = $signed(rot_q[6 + c]);
      endcase
      s  = $signed(side_q[c*CW +: CW]);
      em = e[RW-1] ? RW'(-e) : RW'(e);
      sm = s[CW-1] ? CW'(-s) : CW'(s);
      mr_q[c]   <= em[MRW-1:0];
      ms_q[c]   <= MSW'(sm);
      negp_q[c] <= e[RW-1] ^ s[CW-1];
    end
    case (row_q)
      2'd0:    posp_q <= side_q[3*CW +: CW];
      2'd1:    posp_q <= side_q[4*CW +: CW];
      default: posp_q <= side_q[5*CW +: CW];
    endcase
    rowp_q   <= row_q;
    degenp_q <= degen_q;
  end

  // The scale magnitude is split at bit 24 to keep each product narrow.
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      phi_q[c] <= PW'(mr_q[c]) * PW'(ms_q[c][MSW-1:SPLIT]);
      plo_q[c] <= PW'(mr_q[c]) * PW'(ms_q[c][SPLIT-1:0]);
    end
    negm_q   <= negp_q;
    posm_q   <= posp_q;
    rowm_q   <= rowp_q;
    degenm_q <= degenp_q;
  end

  // Shift right by 28 rounding half away from zero, then saturate.
  always_comb begin
    logic [PW+1:0]   low;
    logic [MAGW-1:0] mag;
    logic [MAGW-1:0] lim;
    for (int c = 0; c < 3; c++) begin
      low = ((PW + 2)'(phi_q[c][3:0]) << SPLIT) + (PW + 2)'(plo_q[c])
          + ((PW + 2)'(1) << (RFRAC - 1));
      mag = MAGW'(phi_q[c] >> 4) + MAGW'(low >> RFRAC);
      lim = MAGW'(1) << (CW - 1);
      if (negm_q[c]) begin
        col_d[c] = (mag >= lim) ? CW'(lim) : CW'(-mag);
      end else begin
        col_d[c] = (mag >= lim) ? CW'(lim - MAGW'(1)) : CW'(mag);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    col0_o       <= col_d[0];
    col1_o       <= col_d[1];
    col2_o       <= col_d[2];
    col3_o       <= posm_q;
    row_index_o  <= rowm_q;
    last_row_o   <= (rowm_q == ROW_LAST);
    degenerate_o <= degenm_q;
  end

  assign result_valid_o = vldo_q;

endmodule
`default_nettype wire

>>> rtl/quat_trs_matrix_build.sv
// Top level of the quaternion translate-rotate-scale matrix row builder.
//
//   channel   handshake                 payload
//   input     start_i / busy_o          quat_x_i..quat_w_i, scale_*_i, pos_*_i
//   result    result_valid_o (strobe)   row_index_o, col0_o..col3_o, last_row_o,
//                                       degenerate_o
//
// An item is taken when start_i is high and busy_o is low; busy_o then stays
// high while gap_q counts down; later items can enter before earlier ones leave.
// The gap is set by the single result port, which shows one row per cycle.
// Rows 0, 1, 2 appear on consecutive cycles after the item has gone through
// normalization, with its 15-stage square root search, rotation and row stages.
// Results cannot be held off. Reset is asynchronous and clears all valid bits.
`timescale 1ns / 1ps
`default_nettype none
module quat_trs_matrix_build import qtm_pkg::*; #(
  parameter int QUAT_WIDTH  = QuatWidthDef,
  parameter int COORD_WIDTH = CoordWidthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic signed [QUAT_WIDTH-1:0]  quat_x_i,
  input  wire logic signed [QUAT_WIDTH-1:0]  quat_y_i,
  input  wire logic signed [QUAT_WIDTH-1:0]  quat_z_i,
  input  wire logic signed [QUAT_WIDTH-1:0]  quat_w_i,
  input  wire logic signed [COORD_WIDTH-1:0] scale_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] scale_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] scale_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] pos_z_i,
  output logic                               result_valid_o,
  output logic             [1:0]             row_index_o,
  output logic signed      [COORD_WIDTH-1:0] col0_o,
  output logic signed      [COORD_WIDTH-1:0] col1_o,
  output logic signed      [COORD_WIDTH-1:0] col2_o,
  output logic signed      [COORD_WIDTH-1:0] col3_o,
  output logic                               last_row_o,
  output logic                               degenerate_o
);

  localparam int SW = 6 * COORD_WIDTH;

  logic                      accept;
  logic [1:0]                gap_d, gap_q;
  logic [SW-1:0]             side_in, side_n, side_r;
  logic [3:0][QOW-1:0]       q_n;
  logic [8:0][RW-1:0]        rot_r;
  ctl_t                      ctl_n, ctl_r;
  logic [COORD_WIDTH-1:0]    c0, c1, c2, c3;

  assign accept = start_i && !busy_o;
  assign busy_o = (gap_q != 2'd0);

  always_comb begin
    gap_d = gap_q;
    if (accept) begin
      gap_d = 2'd2;
    end else if (gap_q != 2'd0) begin
      gap_d = gap_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= 2'd0;
    end else begin
      gap_q <= gap_d;
    end
  end

  assign side_in = {pos_z_i, pos_y_i, pos_x_i, scale_z_i, scale_y_i, scale_x_i};

  qtm_norm #(
    .QW (QUAT_WIDTH),
    .SW (SW)
  ) u_norm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (accept),
    .quat_i     ({quat_w_i, quat_z_i, quat_y_i, quat_x_i}),
    .side_i     (side_in),
    .q_o        (q_n),
    .ctl_o      (ctl_n),
    .side_o     (side_n)
  );

  qtm_rot #(
    .SW (SW)
  ) u_rot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_i    (q_n),
    .ctl_i  (ctl_n),
    .side_i (side_n),
    .rot_o  (rot_r),
    .ctl_o  (ctl_r),
    .side_o (side_r)
  );

  qtm_row #(
    .CW (COORD_WIDTH)
  ) u_row (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rot_i          (rot_r),
    .ctl_i          (ctl_r),
    .side_i         (side_r),
    .result_valid_o (result_valid_o),
    .row_index_o    (row_index_o),
    .col0_o         (c0),
    .col1_o         (c1),
    .col2_o         (c2),
    .col3_o         (c3),
    .last_row_o     (last_row_o),
    .degenerate_o   (degenerate_o)
  );

  assign col0_o = $signed(c0);
  assign col1_o = $signed(c1);
  assign col2_o = $signed(c2);
  assign col3_o = $signed(c3);

endmodule
`default_nettype wire

>>> rtl/qtm_checker.sv
// Port-level checks on row sequencing and input throttling, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
module qtm_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start_i,
  input wire logic       busy_o,
  input wire logic       result_valid_o,
  input wire logic [1:0] row_index_o,
  input wire logic       last_row_o
);

  // The last-row flag marks row two and nothing else.
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (last_row_o == (row_index_o == 2'd2)))
    else $error("last_row disagrees with row_index");

  // Rows of one item follow each other without a gap.
  a_row1_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && row_index_o == 2'd0) |=> (result_valid_o && row_index_o == 2'd1))
    else $error("row 1 did not follow row 0");

  a_row2_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && row_index_o == 2'd1) |=> (result_valid_o && row_index_o == 2'd2))
    else $error("row 2 did not follow row 1");

  // A taken item holds the input off by raising busy_o.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o ##1 busy_o)
    else $error("busy not held after an accepted item");

endmodule

bind quat_trs_matrix_build qtm_checker u_qtm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .row_index_o    (row_index_o),
  .last_row_o     (last_row_o)
);
`default_nettype wire
